/* design/assert_macros.svh */
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* design/rmpt_pkg.sv */
// ----------------------------------------------------------------------------
// rmpt_pkg: shared constants and types
// Field widths, defaults and the peak table entry type.
// ----------------------------------------------------------------------------
`default_nettype none
package rmpt_pkg;
  localparam int SampleW       = 12;
  localparam int TimeW         = 32;
  localparam int RmsW          = 20;
  localparam int MagW          = 21;
  localparam int RankW         = 4;
  localparam int SumW          = 32;
  localparam int SamplesDefault = 64;
  localparam int DepthDefault   = 8;

  typedef struct packed {
    logic [MagW-1:0]  mag;
    logic [RmsW-1:0]  rx;
    logic [RmsW-1:0]  ry;
    logic [RmsW-1:0]  rz;
    logic [TimeW-1:0] ts;
  } entry_t;

  // control handed along the cell row
  typedef struct packed {
    logic   active;   // an insertion wave is moving
    logic   placed;   // the new entry already landed upstream
    entry_t carry;    // entry pushed toward the next cell
  } wave_t;
endpackage
`default_nettype wire

/* design/rmpt_if.sv */
// ----------------------------------------------------------------------------
// rmpt_if: valid/ready channel
// Carries a request with a payload of parameter type.
// ----------------------------------------------------------------------------
`default_nettype none
interface rmpt_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/rmpt_sqrt.sv */
// ----------------------------------------------------------------------------
// rmpt_sqrt: bit-serial integer square root
// One result bit per cycle, restoring method.
// ----------------------------------------------------------------------------
`default_nettype none
module rmpt_sqrt #(
  parameter int InW  = 50,
  parameter int OutW = 25
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [InW-1:0]  radicand,
  output logic                 done,
  output logic [OutW-1:0]      root
);
  localparam int PadW = 2 * OutW;
  localparam int CntW = $clog2(OutW + 1);
  logic [PadW-1:0]  rad_r, rad_nxt;
  logic [OutW+1:0]  rem_r, rem_nxt;
  logic [OutW-1:0]  q_r, q_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [OutW+1:0]  trial, shifted;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r[OutW-1:0], rad_r[PadW-1 -: 2]};
    trial    = {q_r, 2'b01};
    if (start) begin
      rad_nxt  = PadW'(radicand);
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = CntW'(OutW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = rad_r << 2;
      if (shifted >= trial) begin
        rem_nxt = shifted - trial;
        q_nxt   = {q_r[OutW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[OutW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = busy_r && (cnt_r == CntW'(1));
  assign root = q_nxt;
endmodule
`default_nettype wire

/* design/rmpt_cell.sv */
// ----------------------------------------------------------------------------
// rmpt_cell: one peak table slot
// Holds an entry; a passing wave inserts the new entry or shifts it down.
// ----------------------------------------------------------------------------
`default_nettype none
module rmpt_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rmpt_pkg::wave_t wave_in,
  output rmpt_pkg::wave_t     wave_out,
  output logic                took
);
  rmpt_pkg::entry_t ent_r, ent_nxt;
  rmpt_pkg::wave_t  out_r, out_nxt;

  always_comb begin
    ent_nxt = ent_r;
    out_nxt = wave_in;
    took    = 1'b0;
    if (wave_in.active) begin
      if (wave_in.placed) begin
        // shift: take upstream entry, pass own
        ent_nxt       = wave_in.carry;
        out_nxt.carry = ent_r;
      end else if (wave_in.carry.mag > ent_r.mag) begin
        took          = 1'b1;
        ent_nxt       = wave_in.carry;
        out_nxt.carry = ent_r;
        out_nxt.placed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
      out_r <= '0;
    end else begin
      ent_r <= ent_nxt;
      out_r <= out_nxt;
    end
  end

  assign wave_out = out_r;
endmodule
`default_nettype wire

/* design/rms_magnitude_peak_table_top.sv */
// ----------------------------------------------------------------------------
// rms_magnitude_peak_table_top: block RMS with a sorted top-K peak table
// Accumulates squares per axis and ranks each block by magnitude.
// ----------------------------------------------------------------------------
// A sample is taken whenever the block is accumulating. The sample
// that closes a block starts the block-end sequence. Mean squares are
// computed per axis in two steps (an exact reciprocal quotient, then the
// fraction from the remainder), and a last step clears the sums. Four
// bit-serial square roots then produce one result bit per cycle. An
// insertion wave then walks the cell row one slot per cycle, and the result
// then moves into the output register. No sample is taken during that
// sequence. The result waits in the output register until taken; if the
// previous result is still waiting when the next one is ready, the input
// stalls until it goes.
`default_nettype none
module rms_magnitude_peak_table_top #(
  parameter int SAMPLES_PER_BLOCK = rmpt_pkg::SamplesDefault,
  parameter int TABLE_DEPTH       = rmpt_pkg::DepthDefault
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rmpt_if.sink        in_ch,
  rmpt_if.source      out_ch
);
  localparam int SW   = rmpt_pkg::SumW;
  localparam int MW   = SW + 16;          // mean square width
  localparam int CntW = 8;
  localparam int RiW  = $clog2(TABLE_DEPTH + 1);
  localparam int SqW  = 25;
  localparam int LgN  = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 0;
  localparam int RcpW = 34;
  localparam logic [63:0] RecipFull =
    ((64'd1 << (SW + LgN)) + 64'(SAMPLES_PER_BLOCK) - 64'd1) / 64'(SAMPLES_PER_BLOCK);
  localparam logic [RcpW-1:0] Recip = RcpW'(RecipFull);
  localparam logic [2:0] MStepLast = 3'd6;

  typedef enum logic [4:0] {
    S_ACC  = 5'b00001,
    S_MEAN = 5'b00010,
    S_ROOT = 5'b00100,
    S_WAVE = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [SW-1:0]   sx_r, sy_r, sz_r;
  logic [CntW-1:0] cnt_r;
  logic [rmpt_pkg::TimeW-1:0] ts_r;
  logic [MW-1:0]   mx_r, my_r, mz_r;
  logic [SW-1:0]   q1_r;
  logic [2:0]      mstep_r;
  logic [RiW-1:0]  wcnt_r;
  logic [RiW-1:0]  rank_r;
  logic [rmpt_pkg::RmsW-1:0] rx_r, ry_r, rz_r;
  logic [rmpt_pkg::MagW-1:0] mag_r;
  logic [rmpt_pkg::RmsW-1:0] orx_r, ory_r, orz_r;
  logic [rmpt_pkg::MagW-1:0] omag_r;
  logic [RiW-1:0]  orank_r;
  logic            ovalid_r;

  logic in_fire;
  assign in_ch.ready = (state_r == S_ACC);
  assign in_fire = in_ch.valid && in_ch.ready;

  logic [23:0] qx, qy, qz;
  assign qx = in_ch.data.sample_x * in_ch.data.sample_x;
  assign qy = in_ch.data.sample_y * in_ch.data.sample_y;
  assign qz = in_ch.data.sample_z * in_ch.data.sample_z;
  logic closing;
  assign closing = (cnt_r == CntW'(SAMPLES_PER_BLOCK - 1));

  // mean = floor(sum*2^16/N): quotient of sum/N first, then the fraction of
  // the remainder in the next cycle
  logic [SW-1:0]      msum, q1;
  logic [SW+RcpW-1:0] qprod;
  logic [7:0]         rem8;
  logic [24+RcpW-1:0] fprod;
  logic [15:0]        mfrac;
  logic [MW-1:0]      mean_val;
  always_comb begin
    case (mstep_r[2:1])
      2'd0:    msum = sx_r;
      2'd1:    msum = sy_r;
      default: msum = sz_r;
    endcase
    qprod    = (SW+RcpW)'(msum) * (SW+RcpW)'(Recip);
    q1       = SW'(qprod >> (SW + LgN));
    rem8     = 8'(msum - q1_r * SW'(SAMPLES_PER_BLOCK));
    fprod    = (24+RcpW)'({rem8, 16'd0}) * (24+RcpW)'(Recip);
    mfrac    = 16'(fprod >> (SW + LgN));
    mean_val = {q1_r, mfrac};
  end

  logic sq_start, dx, dy, dz, dm;
  logic [SqW-1:0] rtx, rty, rtz, rtm;
  assign sq_start = (state_r == S_MEAN) && (mstep_r == MStepLast);
  rmpt_sqrt #(.InW(MW), .OutW(SqW)) u_sx (.clk, .rst_n, .start(sq_start),
    .radicand(mx_r), .done(dx), .root(rtx));
  rmpt_sqrt #(.InW(MW), .OutW(SqW)) u_sy (.clk, .rst_n, .start(sq_start),
    .radicand(my_r), .done(dy), .root(rty));
  rmpt_sqrt #(.InW(MW), .OutW(SqW)) u_sz (.clk, .rst_n, .start(sq_start),
    .radicand(mz_r), .done(dz), .root(rtz));
  rmpt_sqrt #(.InW(MW), .OutW(SqW)) u_sm (.clk, .rst_n, .start(sq_start),
    .radicand(mx_r + my_r + mz_r), .done(dm), .root(rtm));

  // cell row
  rmpt_pkg::wave_t wv [TABLE_DEPTH+1];
  rmpt_pkg::wave_t wave_head;
  logic [TABLE_DEPTH-1:0] took;
  logic launch;
  assign launch = (state_r == S_ROOT) && dm;
  always_comb begin
    wave_head           = '0;
    wave_head.active    = launch;
    wave_head.carry.mag = rtm[rmpt_pkg::MagW-1:0];
    wave_head.carry.rx  = rtx[rmpt_pkg::RmsW-1:0];
    wave_head.carry.ry  = rty[rmpt_pkg::RmsW-1:0];
    wave_head.carry.rz  = rtz[rmpt_pkg::RmsW-1:0];
    wave_head.carry.ts  = ts_r;
  end
  assign wv[0] = wave_head;
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    rmpt_cell u_cell (.clk, .rst_n, .wave_in(wv[g]), .wave_out(wv[g+1]), .took(took[g]));
  end

  logic [RiW-1:0] took_idx;
  always_comb begin
    took_idx = RiW'(TABLE_DEPTH);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (took[i]) took_idx = RiW'(i);
  end

  logic out_load;
  assign out_load = (state_r == S_OUT) && (!ovalid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_ACC:  if (in_fire && closing) state_nxt = S_MEAN;
      S_MEAN: if (mstep_r == MStepLast) state_nxt = S_ROOT;
      S_ROOT: if (dm) state_nxt = S_WAVE;
      S_WAVE: if (wcnt_r == RiW'(TABLE_DEPTH - 1)) state_nxt = S_OUT;
      S_OUT:  if (!ovalid_r || out_ch.ready) state_nxt = S_ACC;
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_ACC;
      sx_r <= '0; sy_r <= '0; sz_r <= '0;
      cnt_r    <= '0;
      mstep_r  <= '0;
      wcnt_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      if (in_fire) begin
        if (closing) begin
          cnt_r <= '0;
          ts_r  <= in_ch.data.time_stamp;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
        sx_r <= sx_r + SW'(qx);
        sy_r <= sy_r + SW'(qy);
        sz_r <= sz_r + SW'(qz);
        mstep_r <= '0;
      end
      if (state_r == S_MEAN) begin
        if (mstep_r == MStepLast) begin
          sx_r <= '0; sy_r <= '0; sz_r <= '0;
        end else if (!mstep_r[0]) begin
          q1_r <= q1;
        end else begin
          case (mstep_r[2:1])
            2'd0:    mx_r <= mean_val;
            2'd1:    my_r <= mean_val;
            default: mz_r <= mean_val;
          endcase
        end
        mstep_r <= mstep_r + 1'b1;
      end
      // the first cell sees the wave in the launch cycle
      if (launch) begin
        rx_r  <= rtx[rmpt_pkg::RmsW-1:0];
        ry_r  <= rty[rmpt_pkg::RmsW-1:0];
        rz_r  <= rtz[rmpt_pkg::RmsW-1:0];
        mag_r <= rtm[rmpt_pkg::MagW-1:0];
        rank_r <= took_idx;
        wcnt_r <= '0;
      end
      if (state_r == S_WAVE) begin
        wcnt_r <= wcnt_r + 1'b1;
        if (took_idx != RiW'(TABLE_DEPTH)) rank_r <= took_idx;
      end
      if (out_load) begin
        orx_r   <= rx_r;
        ory_r   <= ry_r;
        orz_r   <= rz_r;
        omag_r  <= mag_r;
        orank_r <= rank_r;
      end
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.data.rms_x     = orx_r;
  assign out_ch.data.rms_y     = ory_r;
  assign out_ch.data.rms_z     = orz_r;
  assign out_ch.data.magnitude = omag_r;
  assign out_ch.data.rank      = rmpt_pkg::RankW'(orank_r);

`include "assert_macros.svh"
  `ASSERT_IMPL(a_no_take_busy, clk, rst_n, state_r != S_ACC, !in_ch.ready)
  `ASSERT_IMPL(a_roots_together, clk, rst_n, dm, dx && dy && dz)
  `ASSERT_NEXT(a_hold_out, clk, rst_n, ovalid_r && !out_ch.ready, ovalid_r)
endmodule
`default_nettype wire
